### sv/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define WCRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define WCRM_NEVER(lbl, expr, msg) \
  `WCRM_ASSERT(lbl, !(expr), msg)

`endif

### sv/wcrm_pkg.sv
`default_nettype none
package wcrm_pkg;

  localparam int DEF_HISTORY_DEPTH = 1024;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int NUM_CNT  = 6;
  localparam int NUM_WIN  = 3;
  localparam int CNT_W    = 64;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;
  localparam int WID_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd2;

  localparam logic [WIN_W-1:0] RST_SHORT  = 16'd60;
  localparam logic [WIN_W-1:0] RST_MEDIUM = 16'd300;
  localparam logic [WIN_W-1:0] RST_LONG   = 16'd900;

  localparam logic [WID_W-1:0] WIN_LAST = 2'd2;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_vec_t;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [CNT_W-1:0]  read_sectors;
    logic [CNT_W-1:0]  read_operations;
    logic [CNT_W-1:0]  read_bytes;
    logic [CNT_W-1:0]  write_sectors;
    logic [CNT_W-1:0]  write_operations;
    logic [CNT_W-1:0]  write_bytes;
  } in_item_t;

  typedef struct packed {
    logic [WID_W-1:0] window_id;
    logic [CNT_W-1:0] read_sector_rate;
    logic [CNT_W-1:0] read_op_rate;
    logic [CNT_W-1:0] read_byte_rate;
    logic [CNT_W-1:0] write_sector_rate;
    logic [CNT_W-1:0] write_op_rate;
    logic [CNT_W-1:0] write_byte_rate;
    logic             last_of_run;
  } out_item_t;

endpackage
`default_nettype wire

### sv/wcrm_stream_if.sv
`default_nettype none
interface wcrm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/windowed_counter_rate_meter_core.sv
// channel  | dir | payload           | handshake
// in_if    | in  | wcrm_pkg::in_item_t  | valid/ready
// out_if   | out | wcrm_pkg::out_item_t | valid/ready, three per request
// cfg_*    | in  | 16-bit window length | write enable only
// A request first scans the timestamp memory, one read per cycle, then per window
// reads the counter memory and runs a bit-serial division in six lanes (skipped
// when the rate is forced to zero), then waits for the output to be taken.
// in_if.ready is high only between requests; out_if stalls hold the block.
// Reset is synchronous; history is marked empty by a fill count, no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module windowed_counter_rate_meter_core #(
  parameter int HISTORY_DEPTH = wcrm_pkg::DEF_HISTORY_DEPTH,
  parameter int FRACTION_BITS = wcrm_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  wcrm_stream_if.sink                           in_if,
  wcrm_stream_if.source                         out_if,
  input  wire logic                             cfg_we,
  input  wire logic [wcrm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [wcrm_pkg::WIN_W-1:0]       cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int DW = wcrm_pkg::CNT_W + FRACTION_BITS;
  localparam int BW = $clog2(DW + 1);
  localparam int NC = wcrm_pkg::NUM_CNT;
  localparam int NW = wcrm_pkg::NUM_WIN;
  localparam int TW = wcrm_pkg::TIME_W;
  localparam int CW = wcrm_pkg::CNT_W;
  localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(HISTORY_DEPTH);
  localparam logic [BW-1:0] STEP_LAST = BW'(DW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RDC   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                    st_r;
  logic [wcrm_pkg::WIN_W-1:0]    win_len_r [NW];
  logic [AW-1:0]                 wslot_r;
  logic [AW-1:0]                 wslot_nxt;
  logic [FW-1:0]                 fill_r;
  logic [TW-1:0]                 now_r;
  wcrm_pkg::cnt_vec_t            cur_r;
  wcrm_pkg::cnt_vec_t            cnt_in;
  logic [AW-1:0]                 scan_addr_r;
  logic                          cmp_vld_r;
  logic [AW-1:0]                 cmp_idx_r;
  logic [TW-1:0]                 tm_q_r;
  wcrm_pkg::cnt_vec_t            cm_q_r;
  logic [TW:0]                   best_t_r [NW];
  logic [AW-1:0]                 best_s_r [NW];
  logic                          found_r [NW];
  logic [wcrm_pkg::WID_W-1:0]    win_r;
  logic [TW-1:0]                 sec_r;
  logic [DW-1:0]                 dvd_r [NC];
  logic [TW-1:0]                 rem_r [NC];
  logic [CW-1:0]                 q_r [NC];
  logic                          ovf_r [NC];
  logic [CW-1:0]                 rate_r [NC];
  logic [BW-1:0]                 step_r;
  logic [TW-1:0]                 win_start [NW];
  logic                          qual [NW];
  logic                          in_acc;
  logic                          zero_rate;

  logic [TW-1:0]                 tmem [HISTORY_DEPTH];
  wcrm_pkg::cnt_vec_t            cmem [HISTORY_DEPTH];

  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (st_r == S_IDLE) && rst_n;
  assign wslot_nxt = (wslot_r == SLOT_LAST) ? '0 : wslot_r + 1'b1;
  assign cnt_in = {in_if.data.write_bytes, in_if.data.write_operations,
                   in_if.data.write_sectors, in_if.data.read_bytes,
                   in_if.data.read_operations, in_if.data.read_sectors};
  assign zero_rate = !found_r[win_r] || (best_t_r[win_r][TW-1:0] == now_r);

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      win_start[w] = (now_r > TW'(win_len_r[w])) ? now_r - TW'(win_len_r[w]) : '0;
      qual[w] = cmp_vld_r && (tm_q_r != '0) && (FW'(cmp_idx_r) < fill_r) &&
                (tm_q_r >= win_start[w]) && ({1'b0, tm_q_r} < best_t_r[w]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tmem[wslot_nxt] <= in_if.data.sample_time;
      cmem[wslot_nxt] <= cnt_in;
    end
    tm_q_r <= tmem[scan_addr_r];
    cm_q_r <= cmem[best_s_r[win_r]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r[0] <= wcrm_pkg::RST_SHORT;
      win_len_r[1] <= wcrm_pkg::RST_MEDIUM;
      win_len_r[2] <= wcrm_pkg::RST_LONG;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wcrm_pkg::REG_SHORT:  win_len_r[0] <= cfg_wdata;
        wcrm_pkg::REG_MEDIUM: win_len_r[1] <= cfg_wdata;
        wcrm_pkg::REG_LONG:   win_len_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      wslot_r     <= SLOT_LAST;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      scan_addr_r <= '0;
      win_r       <= '0;
      step_r      <= '0;
    end else begin
      cmp_vld_r <= (st_r == S_SCAN);
      cmp_idx_r <= scan_addr_r;
      for (int w = 0; w < NW; w++) begin
        if (qual[w]) begin
          best_t_r[w] <= {1'b0, tm_q_r};
          best_s_r[w] <= cmp_idx_r;
          found_r[w]  <= 1'b1;
        end
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r       <= in_if.data.sample_time;
            cur_r       <= cnt_in;
            wslot_r     <= wslot_nxt;
            fill_r      <= (fill_r == FILL_MAX) ? fill_r : fill_r + 1'b1;
            scan_addr_r <= '0;
            for (int w = 0; w < NW; w++) begin
              best_t_r[w] <= {1'b0, in_if.data.sample_time} + 1'b1;
              best_s_r[w] <= '0;
              found_r[w]  <= 1'b0;
            end
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr_r == SLOT_LAST) begin
            scan_addr_r <= '0;
            st_r <= S_DRAIN;
          end else begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
        end
        S_DRAIN: begin
          win_r <= '0;
          st_r  <= S_RDC;
        end
        S_RDC: begin
          st_r <= S_LOAD;
        end
        S_LOAD: begin
          sec_r  <= now_r - best_t_r[win_r][TW-1:0];
          step_r <= '0;
          for (int c = 0; c < NC; c++) begin
            logic [CW-1:0] dif;
            dif = cur_r[c] - cm_q_r[c];
            dvd_r[c]  <= DW'(dif) << FRACTION_BITS;
            rem_r[c]  <= '0;
            q_r[c]    <= '0;
            ovf_r[c]  <= 1'b0;
            rate_r[c] <= '0;
          end
          st_r <= zero_rate ? S_OUT : S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < NC; c++) begin
            logic [TW:0] rs;
            logic        ge;
            rs = {rem_r[c], dvd_r[c][DW-1]};
            ge = (rs >= {1'b0, sec_r});
            rem_r[c] <= ge ? TW'(rs - {1'b0, sec_r}) : rs[TW-1:0];
            dvd_r[c] <= dvd_r[c] << 1;
            q_r[c]   <= {q_r[c][CW-2:0], ge};
            ovf_r[c] <= ovf_r[c] | q_r[c][CW-1];
          end
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          for (int c = 0; c < NC; c++) begin
            rate_r[c] <= ovf_r[c] ? '1 : q_r[c];
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_if.ready) begin
            if (win_r == wcrm_pkg::WIN_LAST) begin
              st_r <= S_IDLE;
            end else begin
              win_r <= win_r + 1'b1;
              st_r  <= S_RDC;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid                  = (st_r == S_OUT);
  assign out_if.data.window_id         = win_r;
  assign out_if.data.read_sector_rate  = rate_r[0];
  assign out_if.data.read_op_rate      = rate_r[1];
  assign out_if.data.read_byte_rate    = rate_r[2];
  assign out_if.data.write_sector_rate = rate_r[3];
  assign out_if.data.write_op_rate     = rate_r[4];
  assign out_if.data.write_byte_rate   = rate_r[5];
  assign out_if.data.last_of_run       = (win_r == wcrm_pkg::WIN_LAST);

  `WCRM_NEVER(a_fill_bound, fill_r > FILL_MAX, "fill count beyond history depth")
  `WCRM_NEVER(a_win_range, win_r == 2'd3, "window index out of range")
  `WCRM_NEVER(a_no_overlap, out_if.valid && in_if.ready, "request taken while result pending")
  `WCRM_ASSERT(a_run_end, (out_if.valid && out_if.ready && out_if.data.last_of_run) |=> in_if.ready, "block not idle after last result")

endmodule
`default_nettype wire

### tb/windowed_counter_rate_meter_core_tb.sv
`default_nettype none
module windowed_counter_rate_meter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST = wcrm_pkg::DEF_HISTORY_DEPTH;
  localparam int FRAC = wcrm_pkg::DEF_FRACTION_BITS;
  localparam int CNT_W = wcrm_pkg::CNT_W;
  localparam int TIME_W = wcrm_pkg::TIME_W;
  localparam int WIN_W = wcrm_pkg::WIN_W;
  localparam int WID_W = wcrm_pkg::WID_W;
  localparam int NUM_WIN = wcrm_pkg::NUM_WIN;
  localparam int NUM_CNT = wcrm_pkg::NUM_CNT;
  localparam int LATENCY = HIST + 3 * (FRAC + 70) + 64;
  localparam longint LIMIT = 3_000_000;
  localparam logic [wcrm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [wcrm_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [WIN_W-1:0] cfg_wdata = '0;

  wcrm_stream_if #(.T(wcrm_pkg::in_item_t)) in_if ();
  wcrm_stream_if #(.T(wcrm_pkg::out_item_t)) out_if ();

  windowed_counter_rate_meter_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [TIME_W-1:0] hist_time [HIST];
  wcrm_pkg::cnt_vec_t hist_cnt [HIST];
  int unsigned hist_slot;
  logic [WIN_W-1:0] win_len [NUM_WIN];

  wcrm_pkg::out_item_t rate_q [$];
  int errors = 0;
  bit steady = 1'b0;
  bit hold_on = 1'b0;
  event hold_go;
  longint cycles = 0;

  logic [TIME_W-1:0] clock_now;
  logic [CNT_W-1:0] cnt_now [NUM_CNT];

  function automatic wcrm_pkg::cnt_vec_t counters_of(wcrm_pkg::in_item_t s);
    wcrm_pkg::cnt_vec_t v;
    v[0] = s.read_sectors;
    v[1] = s.read_operations;
    v[2] = s.read_bytes;
    v[3] = s.write_sectors;
    v[4] = s.write_operations;
    v[5] = s.write_bytes;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] fixed_rate(logic [CNT_W-1:0] diff,
                                                  logic [CNT_W-1:0] secs);
    logic [CNT_W+FRAC-1:0] q;
    q = ({{FRAC{1'b0}}, diff} << FRAC) / secs;
    if (q > {{FRAC{1'b0}}, {CNT_W{1'b1}}}) return {CNT_W{1'b1}};
    return q[CNT_W-1:0];
  endfunction

  task automatic predict_rates(wcrm_pkg::in_item_t s);
    wcrm_pkg::cnt_vec_t now_cnt;
    logic [TIME_W:0] best_t [NUM_WIN];
    int unsigned best_i [NUM_WIN];
    logic [TIME_W:0] start;
    logic [TIME_W:0] now;
    wcrm_pkg::cnt_vec_t rates;
    wcrm_pkg::out_item_t r;
    now_cnt = counters_of(s);
    now = {1'b0, s.sample_time};
    hist_slot = (hist_slot + 1) % HIST;
    hist_time[hist_slot] = s.sample_time;
    hist_cnt[hist_slot] = now_cnt;
    for (int w = 0; w < NUM_WIN; w++) begin
      best_t[w] = now + 1;
      best_i[w] = HIST;
    end
    for (int i = 0; i < HIST; i++) begin
      if (hist_time[i] != '0) begin
        for (int w = 0; w < NUM_WIN; w++) begin
          start = (now > win_len[w]) ? now - win_len[w] : '0;
          if ({1'b0, hist_time[i]} >= start && {1'b0, hist_time[i]} < best_t[w]) begin
            best_t[w] = {1'b0, hist_time[i]};
            best_i[w] = i;
          end
        end
      end
    end
    for (int w = 0; w < NUM_WIN; w++) begin
      for (int c = 0; c < NUM_CNT; c++) begin
        if (best_i[w] == HIST || best_t[w] == now) rates[c] = '0;
        else rates[c] = fixed_rate(now_cnt[c] - hist_cnt[best_i[w]][c],
                                   CNT_W'(now - best_t[w]));
      end
      r.window_id = WID_W'(w);
      r.read_sector_rate = rates[0];
      r.read_op_rate = rates[1];
      r.read_byte_rate = rates[2];
      r.write_sector_rate = rates[3];
      r.write_op_rate = rates[4];
      r.write_byte_rate = rates[5];
      r.last_of_run = (WID_W'(w) == wcrm_pkg::WIN_LAST);
      rate_q.push_back(r);
    end
  endtask

  task automatic send_sample(wcrm_pkg::in_item_t s);
    if (!steady && $urandom_range(0, 99) < 28) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= s;
    do @(posedge clk); while (!in_if.ready);
    predict_rates(s);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (rate_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_windows(logic [WIN_W-1:0] s, logic [WIN_W-1:0] m,
                             logic [WIN_W-1:0] l, bit poke_unused);
    drain();
    cfg_we <= 1'b1; cfg_idx <= wcrm_pkg::REG_SHORT; cfg_wdata <= s;
    @(posedge clk);
    cfg_idx <= wcrm_pkg::REG_MEDIUM; cfg_wdata <= m;
    @(posedge clk);
    cfg_idx <= wcrm_pkg::REG_LONG; cfg_wdata <= l;
    @(posedge clk);
    if (poke_unused) begin
      cfg_idx <= REG_UNUSED; cfg_wdata <= WIN_W'($urandom());
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    win_len[0] = s;
    win_len[1] = m;
    win_len[2] = l;
  endtask

  function automatic wcrm_pkg::in_item_t make_sample(logic [TIME_W-1:0] t);
    wcrm_pkg::in_item_t s;
    s.sample_time = t;
    s.read_sectors = cnt_now[0];
    s.read_operations = cnt_now[1];
    s.read_bytes = cnt_now[2];
    s.write_sectors = cnt_now[3];
    s.write_operations = cnt_now[4];
    s.write_bytes = cnt_now[5];
    return s;
  endfunction

  function automatic void fill_counters(logic [CNT_W-1:0] v);
    for (int c = 0; c < NUM_CNT; c++) cnt_now[c] = v;
  endfunction

  task automatic random_samples(int n);
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) clock_now += $urandom_range(1, 20);
      else if (r < 80) clock_now = clock_now;
      else if (r < 87) clock_now = $urandom();
      else if (r < 91) clock_now = '0;
      else if (r < 96) clock_now -= $urandom_range(1, 50);
      else clock_now += $urandom_range(100, 70000);
      for (int c = 0; c < NUM_CNT; c++) begin
        r = $urandom_range(0, 99);
        if (r < 75) cnt_now[c] += $urandom_range(0, 4000);
        else if (r < 88) cnt_now[c] += {$urandom(), $urandom()};
        else if (r < 94) cnt_now[c] = {$urandom(), $urandom()};
      end
      send_sample(make_sample(clock_now));
    end
  endtask

  task automatic test_edge_values();
    fill_counters('0);
    send_sample(make_sample('0));
    send_sample(make_sample(32'd1));
    fill_counters({CNT_W{1'b1}});
    send_sample(make_sample(32'd2));
    fill_counters('0);
    send_sample(make_sample(32'd3));
    send_sample(make_sample(32'd3));
    fill_counters(64'h5555_5555_5555_5555);
    send_sample(make_sample(32'd70));
    fill_counters(64'hAAAA_AAAA_AAAA_AAAA);
    send_sample(make_sample(32'd400));
    send_sample(make_sample(32'd1000));
    send_sample(make_sample({TIME_W{1'b1}}));
    send_sample(make_sample(32'd100));
    send_sample(make_sample('0));
    fill_counters(64'd12345);
    send_sample(make_sample(32'd1050));
    fill_counters(64'd1);
    send_sample(make_sample(32'd1053));
    clock_now = 32'd1053;
  endtask

  task automatic test_window_settings();
    set_windows(16'd5, 16'd30, 16'd120, 1'b1);
    random_samples(35);
    set_windows(16'd0, 16'd7, 16'd16, 1'b0);
    random_samples(25);
    set_windows(16'd1, 16'd2, 16'hFFFF, 1'b0);
    random_samples(25);
    set_windows(WIN_W'($urandom_range(1, 200)), WIN_W'($urandom_range(1, 200)),
                WIN_W'($urandom_range(1, 200)), 1'b1);
    random_samples(30);
    set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    random_samples(20);
  endtask

  task automatic test_steady_stream();
    set_windows(16'd10, 16'd40, 16'd90, 1'b0);
    steady = 1'b1;
    random_samples(40);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    -> hold_go;
    random_samples(6);
    drain();
    random_samples(30);
  endtask

  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (4000) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else if (hold_on) out_if.ready <= 1'b0;
    else out_if.ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %h actual %h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    wcrm_pkg::out_item_t want;
    wcrm_pkg::out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (rate_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $realtime, got);
      end else begin
        want = rate_q.pop_front();
        check_field("window_id", want.window_id, got.window_id);
        check_field("read_sector_rate", want.read_sector_rate, got.read_sector_rate);
        check_field("read_op_rate", want.read_op_rate, got.read_op_rate);
        check_field("read_byte_rate", want.read_byte_rate, got.read_byte_rate);
        check_field("write_sector_rate", want.write_sector_rate, got.write_sector_rate);
        check_field("write_op_rate", want.write_op_rate, got.write_op_rate);
        check_field("write_byte_rate", want.write_byte_rate, got.write_byte_rate);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    for (int i = 0; i < HIST; i++) begin
      hist_time[i] = '0;
      hist_cnt[i] = '0;
    end
    hist_slot = HIST - 1;
    win_len[0] = wcrm_pkg::RST_SHORT;
    win_len[1] = wcrm_pkg::RST_MEDIUM;
    win_len[2] = wcrm_pkg::RST_LONG;
    fill_counters('0);
    clock_now = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_values();
    random_samples(20);
    test_window_settings();
    test_steady_stream();
    test_backpressure();
    stop_sending();
    while (rate_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
